@@ hw/rtl/stack_machine_executor_macros.svh @@
// Assertion helpers shared by the RTL of the stack machine executor.
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

// Concurrent check on the rising clock, off while reset is asserted.
`define SMX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, also evaluated during reset.
`define SMX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/smx_pkg.sv @@
`timescale 1ns / 1ps

package smx_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned INSTR_W     = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_W     = 8;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned IMM_W       = 30;
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  typedef enum logic [1:0] {
    TY_PUSH  = 2'd0,
    TY_PRIM  = 2'd1,
    TY_PUSHS = 2'd2,
    TY_BAD   = 2'd3
  } instr_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_DIVZ    = 3'd4,
    ST_TYPE3   = 3'd5,
    ST_BADPRIM = 3'd6,
    ST_STOPPED = 3'd7
  } status_e;

  localparam logic [IMM_W-1:0] PRIM_HALT = 30'd0;
  localparam logic [IMM_W-1:0] PRIM_ADD  = 30'd1;
  localparam logic [IMM_W-1:0] PRIM_SUB  = 30'd2;
  localparam logic [IMM_W-1:0] PRIM_MUL  = 30'd3;
  localparam logic [IMM_W-1:0] PRIM_DIV  = 30'd4;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } smx_alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } smx_alu_rsp_t;

endpackage

@@ hw/rtl/stack_machine_executor.sv @@
`timescale 1ns / 1ps
// Stack machine executor: runs one instruction word per input transfer on a
// LIFO of signed 32-bit values and returns one result transfer per word.
// Input channel: in_valid_i / in_stall_o with instr_i. Output channel:
// out_valid_o / out_stall_i with status_o, top_value_o, top_valid_o and
// depth_o. A transfer happens at a clock edge where valid is high and stall
// is low.
// Pushes, halt, errors and stopped reports go from the input transfer
// straight to the response state; add, sub, mul and div pass the read and
// operate states; div waits there on the shared ALU, one quotient bit per cycle.
// in_stall_o is high from the input transfer until the result is loaded
// into the output register, so one item is in work at a time and the next
// item may be taken while the previous result still waits.
// If out_stall_i holds a result, a finished item waits in the sequencer and
// the input stays stalled until the output register frees.
// Reset (rst_ni low, asynchronous) empties the stack and starts the machine
// running; stack memory contents are not cleared. After halt or any error
// every later word reports stopped until the next reset.

`include "stack_machine_executor_macros.svh"

module stack_machine_executor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [smx_pkg::INSTR_W-1:0]  instr_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [smx_pkg::STATUS_W-1:0] status_o,
  output logic signed [smx_pkg::DATA_W-1:0] top_value_o,
  output logic                         top_valid_o,
  output logic [smx_pkg::DEPTH_W-1:0]  depth_o
);

  import smx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OPER,
    S_RESP
  } seq_state_e;

  seq_state_e        state_q;
  logic [CNT_W-1:0]  count_q;
  logic              running_q;
  logic [DATA_W-1:0] top_q;
  status_e           status_q;
  alu_op_e           op_q;
  logic              out_valid_q;

  instr_type_e       ty;
  logic [IMM_W-1:0]  imm;
  logic [DATA_W-1:0] push_val;
  status_e           dec_status;
  logic              dec_push;
  logic              dec_binop;
  alu_op_e           dec_op;
  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  cnt_m2;
  logic [31:0]       cnt_ext;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  smx_alu_req_t      alu_req;
  smx_alu_rsp_t      alu_rsp;

  assign ty       = instr_type_e'(instr_i[INSTR_W-1:INSTR_W-2]);
  assign imm      = instr_i[IMM_W-1:0];
  assign push_val = (ty == TY_PUSHS && imm[IMM_W-1]) ? {2'b11, imm} : {2'b00, imm};
  assign cnt_m2   = count_q - CNT_W'(2);
  assign cnt_ext  = 32'(count_q);

  always_comb begin
    dec_status = ST_OK;
    dec_push   = 1'b0;
    dec_binop  = 1'b0;
    dec_op     = ALU_ADD;
    case (imm)
      PRIM_SUB: dec_op = ALU_SUB;
      PRIM_MUL: dec_op = ALU_MUL;
      PRIM_DIV: dec_op = ALU_DIV;
      default:  dec_op = ALU_ADD;
    endcase
    if (!running_q) begin
      dec_status = ST_STOPPED;
    end else begin
      case (ty)
        TY_PUSH, TY_PUSHS: begin
          if (count_q == CNT_W'(STACK_DEPTH)) begin
            dec_status = ST_OVER;
          end else begin
            dec_push = 1'b1;
          end
        end
        TY_PRIM: begin
          if (imm == PRIM_HALT) begin
            dec_status = ST_HALT;
          end else if (imm > PRIM_DIV) begin
            dec_status = ST_BADPRIM;
          end else if (count_q < CNT_W'(2)) begin
            dec_status = ST_UNDER;
          end else if (imm == PRIM_DIV && top_q == '0) begin
            dec_status = ST_DIVZ;
          end else begin
            dec_binop = 1'b1;
          end
        end
        default: dec_status = ST_TYPE3;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // pushes write at the transfer, operations write back under the old second entry
  assign ram_we    = (accept && dec_push) || (state_q == S_OPER && alu_rsp.done);
  assign ram_waddr = (state_q == S_IDLE) ? count_q[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
  assign ram_wdata = (state_q == S_IDLE) ? push_val : alu_rsp.result;

  smx_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_m2[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign alu_req.start = (state_q == S_READ);
  assign alu_req.op    = op_q;
  assign alu_req.a     = ram_rdata;
  assign alu_req.b     = top_q;

  smx_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      running_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // drop the sent result unless a new one is loaded this cycle
      if (out_valid_q && !out_stall_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= dec_status;
            op_q     <= dec_op;
            if (dec_status != ST_OK) begin
              running_q <= 1'b0;
            end
            if (dec_push) begin
              top_q   <= push_val;
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= dec_binop ? S_READ : S_RESP;
          end
        end
        S_READ: begin
          state_q <= S_OPER;
        end
        S_OPER: begin
          if (alu_rsp.done) begin
            top_q   <= alu_rsp.result;
            count_q <= count_q - CNT_W'(1);
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_o    <= status_q;
            top_value_o <= (count_q != '0) ? $signed(top_q) : '0;
            top_valid_o <= (count_q != '0);
            depth_o     <= cnt_ext[DEPTH_W-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `SMX_ASSERT(a_count_bound, count_q <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `SMX_ASSERT(a_stop_sticky, !running_q |=> !running_q, "machine restarted without reset")
  `SMX_ASSERT(a_alu_wait, alu_rsp.done |-> state_q == S_OPER, "alu result with no consumer")
  `SMX_ASSERT(a_stopped_frozen, (!running_q && state_q == S_IDLE) |=> $stable(count_q),
              "stack changed while stopped")

endmodule

@@ hw/rtl/smx_ram.sv @@
`timescale 1ns / 1ps

module smx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/smx_alu.sv @@
`timescale 1ns / 1ps

`include "stack_machine_executor_macros.svh"

module smx_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smx_pkg::smx_alu_req_t req_i,
  output smx_pkg::smx_alu_rsp_t rsp_o
);

  import smx_pkg::*;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX
  } alu_state_e;

  alu_state_e           state_q;
  logic                 done_q;
  logic [DATA_W-1:0]    res_q;
  logic [DATA_W-1:0]    quo_q;
  logic [DATA_W-1:0]    rem_q;
  logic [DATA_W-1:0]    mb_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic [DATA_W-1:0] ma;
  logic [DATA_W-1:0] mb;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] prod;

  assign ma        = req_i.a[DATA_W-1] ? (DATA_W'(0) - req_i.a) : req_i.a;
  assign mb        = req_i.b[DATA_W-1] ? (DATA_W'(0) - req_i.b) : req_i.b;
  assign rem_shift = {rem_q, quo_q[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, mb_q};
  assign prod      = req_i.a * req_i.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        A_IDLE: begin
          done_q <= req_i.start && (req_i.op != ALU_DIV);
          if (req_i.start) begin
            case (req_i.op)
              ALU_ADD: begin
                res_q <= req_i.a + req_i.b;
              end
              ALU_SUB: begin
                res_q <= req_i.a - req_i.b;
              end
              ALU_MUL: begin
                res_q <= prod;
              end
              default: begin
                // magnitudes in, sign applied once the quotient is complete
                quo_q   <= ma;
                rem_q   <= '0;
                mb_q    <= mb;
                neg_q   <= req_i.a[DATA_W-1] ^ req_i.b[DATA_W-1];
                cnt_q   <= '0;
                state_q <= A_DIV;
              end
            endcase
          end
        end
        A_DIV: begin
          if (!diff[DATA_W]) begin
            rem_q <= diff[DATA_W-1:0];
            quo_q <= {quo_q[DATA_W-2:0], 1'b1};
          end else begin
            rem_q <= rem_shift[DATA_W-1:0];
            quo_q <= {quo_q[DATA_W-2:0], 1'b0};
          end
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
            state_q <= A_FIX;
          end
        end
        A_FIX: begin
          res_q   <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  `SMX_ASSERT(a_done_pulse, done_q |=> !done_q, "alu done held longer than one cycle")
  `SMX_ASSERT(a_start_idle, req_i.start |-> state_q == A_IDLE, "alu started while busy")
  `SMX_ASSERT(a_div_done, (state_q == A_FIX) |=> (done_q && state_q == A_IDLE),
              "division finished without done")

endmodule

@@ test/stack_machine_executor_test.sv @@
`timescale 1ns / 1ps

module stack_machine_executor_test;
  import smx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  top_value;
    logic                      top_valid;
    logic [DEPTH_W-1:0]        depth;
  } step_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [INSTR_W-1:0]        instr_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [STATUS_W-1:0]       status_o;
  logic signed [DATA_W-1:0]  top_value_o;
  logic                      top_valid_o;
  logic [DEPTH_W-1:0]        depth_o;

  stack_machine_executor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .instr_i     (instr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .top_value_o (top_value_o),
    .top_valid_o (top_valid_o),
    .depth_o     (depth_o)
  );

  logic [INSTR_W-1:0] pending_words[$];
  step_result_t       expected_results[$];
  step_result_t       want;

  // Shadow machine state
  logic [DATA_W-1:0]  mach_stack [STACK_DEPTH];
  int unsigned        mach_count = 0;
  bit                 mach_running = 1'b1;
  status_e            stop_cause = ST_OK;
  int unsigned        deepest = 0;

  int unsigned        gen_depth = 0;
  int unsigned        planned_words = 0;
  int unsigned        words_taken = 0;
  int unsigned        results_checked = 0;
  int unsigned        stopped_seen = 0;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        hold_left = 0;
  bit                 hold_used = 1'b0;
  logic               in_fired = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic step_result_t execute_word(logic [INSTR_W-1:0] word);
    step_result_t      res;
    instr_type_e       itype;
    logic [IMM_W-1:0]  imm;
    logic [DATA_W-1:0] lhs, rhs, value, mag_l, mag_r, quo;
    status_e           st;
    itype = instr_type_e'(word[31:30]);
    imm = word[IMM_W-1:0];
    st = ST_OK;
    value = '0;
    if (!mach_running) begin
      st = ST_STOPPED;
    end else begin
      case (itype)
        TY_PUSH, TY_PUSHS: begin
          value = {2'b00, imm};
          if (itype == TY_PUSHS && imm[IMM_W-1]) value[31:30] = 2'b11;
          if (mach_count >= STACK_DEPTH) begin
            st = ST_OVER;
          end else begin
            mach_stack[mach_count] = value;
            mach_count++;
          end
        end
        TY_BAD: st = ST_TYPE3;
        default: begin
          if (imm == PRIM_HALT) begin
            st = ST_HALT;
          end else if (imm > PRIM_DIV) begin
            st = ST_BADPRIM;
          end else if (mach_count < 2) begin
            st = ST_UNDER;
          end else begin
            rhs = mach_stack[mach_count-1];
            lhs = mach_stack[mach_count-2];
            case (imm)
              PRIM_ADD: value = lhs + rhs;
              PRIM_SUB: value = lhs - rhs;
              PRIM_MUL: value = lhs * rhs;
              default: begin
                if (rhs == '0) begin
                  st = ST_DIVZ;
                end else begin
                  // divide magnitudes, then fix the sign: truncates toward zero
                  mag_l = lhs[31] ? -lhs : lhs;
                  mag_r = rhs[31] ? -rhs : rhs;
                  quo = mag_l / mag_r;
                  value = (lhs[31] ^ rhs[31]) ? -quo : quo;
                end
              end
            endcase
            if (st == ST_OK) begin
              mach_count--;
              mach_stack[mach_count-1] = value;
            end
          end
        end
      endcase
      if (st != ST_OK) begin
        mach_running = 1'b0;
        stop_cause = st;
      end
    end
    if (mach_count > deepest) deepest = mach_count;
    res.status = st;
    res.top_valid = (mach_count > 0);
    res.top_value = (mach_count > 0) ? mach_stack[mach_count-1] : '0;
    res.depth = DEPTH_W'(mach_count);
    return res;
  endfunction

  function automatic logic [IMM_W-1:0] random_imm();
    case ($urandom_range(7))
      0: return IMM_W'($urandom_range(15));
      1: return '1;
      2: return 30'h2000_0000;
      3: return 30'h1FFF_FFFF;
      default: return IMM_W'($urandom);
    endcase
  endfunction

  task automatic queue_word(logic [INSTR_W-1:0] word);
    pending_words.push_back(word);
  endtask

  task automatic queue_push(bit sign_ext, logic [IMM_W-1:0] imm);
    queue_word({sign_ext ? TY_PUSHS : TY_PUSH, imm});
    gen_depth++;
  endtask

  // Arithmetic only: the caller makes sure it cannot fail
  task automatic queue_prim(logic [IMM_W-1:0] code);
    queue_word({TY_PRIM, code});
    gen_depth--;
  endtask

  function automatic int unsigned idle_pct(bit for_receiver);
    if (words_taken >= 2 * planned_words / 3) return 0;
    if ((words_taken < planned_words / 3) == for_receiver) return 70;
    return 30;
  endfunction

  // Driver: advance to the next word once the current one is transferred
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        in_valid_i <= 1'b1;
        instr_i <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps going
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_used && planned_words != 0 && words_taken >= 5 * planned_words / 6) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rst_ni && ($urandom_range(99) < idle_pct(1'b1));
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(execute_word(instr_i));
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no instruction word outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.status == ST_STOPPED) stopped_seen++;
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            error_count++;
          end
          if (top_value_o !== want.top_value) begin
            $error("top_value mismatch: expected %0d, actual %0d",
                   want.top_value, top_value_o);
            error_count++;
          end
          if (top_valid_o !== want.top_valid) begin
            $error("top_valid mismatch: expected %0d, actual %0d",
                   want.top_valid, top_valid_o);
            error_count++;
          end
          if (depth_o !== want.depth) begin
            $error("depth mismatch: expected %0d, actual %0d", want.depth, depth_o);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("stack_machine_executor test failed");
    $finish;
  end

  initial begin
    bit               grow;
    logic [IMM_W-1:0] imm;

    // Directed: immediate extremes, every arithmetic primitive, most negative / -1
    queue_push(1'b0, '0);
    queue_push(1'b0, '1);
    queue_push(1'b1, '1);
    queue_push(1'b1, 30'h1FFF_FFFF);
    queue_prim(PRIM_ADD);
    queue_prim(PRIM_SUB);
    queue_prim(PRIM_MUL);
    queue_push(1'b1, 30'h2000_0000);
    queue_push(1'b0, 30'd4);
    queue_prim(PRIM_MUL);
    queue_push(1'b1, '1);
    queue_prim(PRIM_DIV);
    queue_push(1'b0, 30'd7);
    queue_prim(PRIM_DIV);
    queue_push(1'b1, 30'h3FFF_FFFD);
    queue_prim(PRIM_DIV);
    queue_push(1'b1, 30'h2000_0000);
    queue_push(1'b0, 30'd4);
    queue_prim(PRIM_MUL);
    queue_push(1'b1, 30'h2000_0000);
    queue_push(1'b0, 30'd4);
    queue_prim(PRIM_MUL);
    queue_prim(PRIM_ADD);

    // Random well-formed program: swing between shallow and a full stack
    grow = 1'b1;
    while (pending_words.size() < 598) begin
      if (gen_depth >= STACK_DEPTH) grow = 1'b0;
      else if (gen_depth < 4) grow = 1'b1;
      if (gen_depth < 2 ||
          (gen_depth < STACK_DEPTH && $urandom_range(99) < (grow ? 85 : 25))) begin
        queue_push($urandom_range(1), random_imm());
      end else begin
        case ($urandom_range(3))
          0: queue_prim(PRIM_ADD);
          1: queue_prim(PRIM_SUB);
          2: queue_prim(PRIM_MUL);
          default: begin
            if (gen_depth < STACK_DEPTH) begin
              // push a nonzero divisor right before the divide
              imm = random_imm();
              if (imm == '0) imm = 30'd1;
              queue_push($urandom_range(1), imm);
              queue_prim(PRIM_DIV);
            end else begin
              queue_prim(PRIM_SUB);
            end
          end
        endcase
      end
    end

    // One way to stop the machine, then words that must report stopped
    case ($urandom_range(5))
      0: queue_word({TY_PRIM, PRIM_HALT});
      1: begin
        while (gen_depth > 1) queue_prim(PRIM_ADD);
        queue_word({TY_PRIM, IMM_W'($urandom_range(4, 1))});
      end
      2: begin
        while (gen_depth < STACK_DEPTH) queue_push($urandom_range(1), random_imm());
        queue_word({TY_PUSH, random_imm()});
      end
      3: begin
        queue_push(1'b0, '0);
        queue_word({TY_PRIM, PRIM_DIV});
      end
      4: queue_word({TY_BAD, IMM_W'($urandom)});
      default: queue_word({TY_PRIM, IMM_W'($urandom_range(30'h3FFF_FFFF, 5))});
    endcase
    repeat (20) queue_word($urandom);
    planned_words = pending_words.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Executed %0d instruction words, checked %0d results, stack peaked at %0d of %0d.",
             words_taken, results_checked, deepest, STACK_DEPTH);
    $display("Machine stopped with status %0d; %0d later words reported stopped.",
             stop_cause, stopped_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("stack_machine_executor test passed");
    end else begin
      $display("stack_machine_executor test failed");
    end
    $finish;
  end

endmodule
